// ===== rtl/ffca_pkg.sv =====
// ============================================================================
// ffca_pkg
// Shared constants, codes and types of the first-fit coalescing allocator.
// ============================================================================
package ffca_pkg;

    localparam int PAGE_BYTES   = 4096;
    localparam int FREE_SLOTS   = 64;
    localparam int USED_SLOTS   = 256;
    localparam int HEADER_BYTES = 32;

    localparam int FREE_IDX_W = $clog2(FREE_SLOTS);
    localparam int FREE_CNT_W = FREE_IDX_W + 1;
    localparam int USED_IDX_W = $clog2(USED_SLOTS);
    localparam int USED_CNT_W = USED_IDX_W + 1;

    localparam logic [31:0] HDR32   = 32'(HEADER_BYTES);
    localparam logic [31:0] PAGE32  = 32'(PAGE_BYTES);
    localparam logic [31:0] GRAIN32 = 32'd16;
    localparam logic [31:0] ROUND32 = 32'd15;

    typedef enum logic [1:0] {
        KIND_ALLOC    = 2'd0,
        KIND_FREE     = 2'd1,
        KIND_ADD_PAGE = 2'd2,
        KIND_NOP      = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_ZERO_SIZE  = 3'd1,
        ST_TOO_LARGE  = 3'd2,
        ST_NO_FIT     = 3'd3,
        ST_DOUBLE     = 3'd4,
        ST_UNKNOWN    = 3'd5,
        ST_TABLE_FULL = 3'd6
    } status_t;

    typedef struct packed {
        logic [31:0] start;
        logic [31:0] bytes;
    } free_entry_t;

    typedef struct packed {
        logic [31:0] start;
        logic [15:0] bytes;
    } used_entry_t;

endpackage

// ===== rtl/ffca_if.sv =====
// ============================================================================
// ffca interfaces
// Valid/ready channels for request beats and response beats.
// ============================================================================
interface ffca_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [15:0] request_bytes;
    logic [31:0] address;

    modport source (output valid, kind, request_bytes, address, input ready);
    modport sink   (input valid, kind, request_bytes, address, output ready);
endinterface

interface ffca_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] payload_address;
    logic [15:0] granted_bytes;
    logic [2:0]  status;

    modport source (output valid, payload_address, granted_bytes, status, input ready);
    modport sink   (input valid, payload_address, granted_bytes, status, output ready);
endinterface

// ===== rtl/ffca_cell.sv =====
// ============================================================================
// ffca_cell
// One slot of the free table; loads the entry on its d input on shift.
// ============================================================================
module ffca_cell
    import ffca_pkg::*;
(
    input  logic        clk,
    input  logic        shift,
    input  free_entry_t d,
    output free_entry_t q
);

    free_entry_t entry_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            entry_reg <= d;
        end
    end

    assign q = entry_reg;

endmodule

// ===== rtl/ffca_free_chain.sv =====
// ============================================================================
// ffca_free_chain
// Row of free-table cells shifting toward the head; the tail takes the
// controller's rewritten stream.
// ============================================================================
module ffca_free_chain
    import ffca_pkg::*;
(
    input  logic        clk,
    input  logic        shift,
    input  free_entry_t tail,
    output free_entry_t head,
    output free_entry_t second
);

    free_entry_t cell_q [FREE_SLOTS];

    for (genvar i = 0; i < FREE_SLOTS; i++)
    begin : g_cell
        free_entry_t cell_d;
        if (i == FREE_SLOTS - 1)
        begin : g_last
            assign cell_d = tail;
        end
        else
        begin : g_mid
            assign cell_d = cell_q[i + 1];
        end
        ffca_cell u_cell (
            .clk   (clk),
            .shift (shift),
            .d     (cell_d),
            .q     (cell_q[i])
        );
    end

    assign head   = cell_q[0];
    assign second = cell_q[1];

endmodule

// ===== rtl/first_fit_coalescing_allocator_unit.sv =====
// ============================================================================
// first_fit_coalescing_allocator_unit
// First-fit heap allocator with an address-ordered, coalescing free table.
// ============================================================================
// channel | dir | beat contents
// req     | in  | kind, request_bytes, address
// rsp     | out | payload_address, granted_bytes, status
//
// One request at a time. Each free-table pass rotates the whole cell row
// once: a scan pass, then an edit pass when the table changes.
// Free also walks the granted table with a registered RAM read: a read state
// and a compare state per entry, then a read state and a write state to move
// the last entry into the freed slot.
// Reset empties both tables at once. A new request is taken while a
// response waits; the next response holds until that one is taken.
// ============================================================================
module first_fit_coalescing_allocator_unit
    import ffca_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    ffca_req_if.sink   req,
    ffca_rsp_if.source rsp
);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_PREP   = 10'b0000000010,
        S_SCAN   = 10'b0000000100,
        S_UREAD  = 10'b0000001000,
        S_UCMP   = 10'b0000010000,
        S_DECIDE = 10'b0000100000,
        S_EDIT   = 10'b0001000000,
        S_MVREAD = 10'b0010000000,
        S_MVWAIT = 10'b0100000000,
        S_DONE   = 10'b1000000000
    } state_t;

    localparam logic [FREE_IDX_W-1:0] LAST_T = FREE_IDX_W'(FREE_SLOTS - 1);

    state_t state_reg, state_next;
    kind_t  kind_reg, kind_next;
    logic [15:0] req_reg, req_next;
    logic [31:0] h_reg, h_next;
    logic [31:0] size_reg, size_next;

    logic [FREE_IDX_W-1:0] t_reg, t_next;
    logic found_reg, found_next;
    logic dbl_reg, dbl_next;
    logic has_prev_reg, has_prev_next;
    logic [FREE_IDX_W-1:0] hit_idx_reg, hit_idx_next;
    logic [FREE_IDX_W-1:0] prev_idx_reg, prev_idx_next;
    free_entry_t hit_reg, hit_next;
    free_entry_t prev_reg, prev_next;

    logic [FREE_CNT_W-1:0] free_cnt_reg, free_cnt_next;
    logic [USED_CNT_W-1:0] used_cnt_reg, used_cnt_next;
    logic [USED_IDX_W-1:0] uk_reg, uk_next;

    logic mod_en_reg, mod_en_next, del_en_reg, del_en_next, ins_en_reg, ins_en_next;
    logic [FREE_IDX_W-1:0] mod_idx_reg, mod_idx_next;
    logic [FREE_IDX_W-1:0] del_idx_reg, del_idx_next;
    logic [FREE_IDX_W-1:0] ins_idx_reg, ins_idx_next;
    free_entry_t mod_val_reg, mod_val_next, ins_val_reg, ins_val_next;
    free_entry_t dly_reg, dly_next;

    logic [31:0] res_pay_reg, res_pay_next;
    logic [15:0] res_gr_reg, res_gr_next;
    status_t     res_st_reg, res_st_next;

    logic        rsp_valid_reg, rsp_valid_next;
    logic [31:0] rsp_pay_reg, rsp_pay_next;
    logic [15:0] rsp_gr_reg, rsp_gr_next;
    logic [2:0]  rsp_st_reg, rsp_st_next;

    used_entry_t used_mem [USED_SLOTS];
    used_entry_t rd_data_reg;
    logic [USED_IDX_W-1:0] rd_addr, wa;
    used_entry_t wd;
    logic we;

    logic        shift;
    free_entry_t head, second, tail, base;
    logic        live, dbl_now;
    logic [31:0] merged, end_h, prev_end;
    logic        nm, pm;

    ffca_free_chain u_chain (
        .clk    (clk),
        .shift  (shift),
        .tail   (tail),
        .head   (head),
        .second (second)
    );

    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid = rsp_valid_reg;
    assign rsp.payload_address = rsp_pay_reg;
    assign rsp.granted_bytes   = rsp_gr_reg;
    assign rsp.status          = rsp_st_reg;

    assign live     = ({1'b0, t_reg} < free_cnt_reg);
    assign end_h    = h_reg + HDR32 + size_reg;
    assign prev_end = prev_reg.start + HDR32 + prev_reg.bytes;
    assign merged   = size_reg + HDR32 + hit_reg.bytes;
    assign nm       = found_reg && (end_h == hit_reg.start);
    assign pm       = has_prev_reg && (prev_end == h_reg);
    assign dbl_now  = dbl_reg | (live && (kind_reg != KIND_ALLOC) && (head.start == h_reg));

    always_comb
    begin
        if (ins_en_reg && (t_reg > ins_idx_reg))
        begin
            base = dly_reg;
        end
        else if (del_en_reg && (t_reg >= del_idx_reg))
        begin
            base = second;
        end
        else
        begin
            base = head;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        req_next       = req_reg;
        h_next         = h_reg;
        size_next      = size_reg;
        t_next         = t_reg;
        found_next     = found_reg;
        dbl_next       = dbl_reg;
        has_prev_next  = has_prev_reg;
        hit_idx_next   = hit_idx_reg;
        prev_idx_next  = prev_idx_reg;
        hit_next       = hit_reg;
        prev_next      = prev_reg;
        free_cnt_next  = free_cnt_reg;
        used_cnt_next  = used_cnt_reg;
        uk_next        = uk_reg;
        mod_en_next    = mod_en_reg;
        del_en_next    = del_en_reg;
        ins_en_next    = ins_en_reg;
        mod_idx_next   = mod_idx_reg;
        del_idx_next   = del_idx_reg;
        ins_idx_next   = ins_idx_reg;
        mod_val_next   = mod_val_reg;
        ins_val_next   = ins_val_reg;
        dly_next       = dly_reg;
        res_pay_next   = res_pay_reg;
        res_gr_next    = res_gr_reg;
        res_st_next    = res_st_reg;
        rsp_valid_next = rsp_valid_reg & ~rsp.ready;
        rsp_pay_next   = rsp_pay_reg;
        rsp_gr_next    = rsp_gr_reg;
        rsp_st_next    = rsp_st_reg;
        shift          = 1'b0;
        tail           = head;
        we             = 1'b0;
        wa             = uk_reg;
        wd             = rd_data_reg;
        rd_addr        = uk_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    kind_next     = kind_t'(req.kind);
                    req_next      = req.request_bytes;
                    h_next        = (kind_t'(req.kind) == KIND_FREE) ?
                                    (req.address - HDR32) : req.address;
                    size_next     = (kind_t'(req.kind) == KIND_ALLOC) ?
                                    (({16'b0, req.request_bytes} + ROUND32) & ~ROUND32) :
                                    (PAGE32 - HDR32);
                    res_pay_next  = '0;
                    res_gr_next   = '0;
                    res_st_next   = ST_OK;
                    t_next        = '0;
                    found_next    = 1'b0;
                    dbl_next      = 1'b0;
                    has_prev_next = 1'b0;
                    state_next    = S_PREP;
                end
            end
            S_PREP:
            begin
                unique case (kind_reg)
                    KIND_NOP:
                    begin
                        state_next = S_DONE;
                    end
                    KIND_ALLOC:
                    begin
                        priority if (req_reg == '0)
                        begin
                            res_st_next = ST_ZERO_SIZE;
                            state_next  = S_DONE;
                        end
                        else if (size_reg + HDR32 > PAGE32)
                        begin
                            res_st_next = ST_TOO_LARGE;
                            state_next  = S_DONE;
                        end
                        else if (used_cnt_reg >= USED_CNT_W'(USED_SLOTS))
                        begin
                            res_st_next = ST_TABLE_FULL;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                    default:
                    begin
                        state_next = S_SCAN;
                    end
                endcase
            end
            S_SCAN:
            begin
                shift  = 1'b1;
                tail   = head;
                t_next = t_reg + 1'b1;
                if (live)
                begin
                    if (kind_reg == KIND_ALLOC)
                    begin
                        if (!found_reg && (head.bytes >= size_reg))
                        begin
                            found_next   = 1'b1;
                            hit_idx_next = t_reg;
                            hit_next     = head;
                        end
                    end
                    else
                    begin
                        dbl_next = dbl_now;
                        if (!found_reg)
                        begin
                            if (head.start < h_reg)
                            begin
                                prev_next     = head;
                                prev_idx_next = t_reg;
                                has_prev_next = 1'b1;
                            end
                            else
                            begin
                                found_next   = 1'b1;
                                hit_idx_next = t_reg;
                                hit_next     = head;
                            end
                        end
                    end
                end
                if (t_reg == LAST_T)
                begin
                    t_next = '0;
                    priority if (kind_reg == KIND_ALLOC)
                    begin
                        state_next = S_DECIDE;
                    end
                    else if (dbl_now)
                    begin
                        res_st_next = ST_DOUBLE;
                        state_next  = S_DONE;
                    end
                    else if (kind_reg == KIND_ADD_PAGE)
                    begin
                        state_next = S_DECIDE;
                    end
                    else if (used_cnt_reg == '0)
                    begin
                        res_st_next = ST_UNKNOWN;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        uk_next    = '0;
                        state_next = S_UREAD;
                    end
                end
            end
            S_UREAD:
            begin
                rd_addr    = uk_reg;
                state_next = S_UCMP;
            end
            S_UCMP:
            begin
                priority if (rd_data_reg.start == h_reg)
                begin
                    size_next  = {16'b0, rd_data_reg.bytes};
                    state_next = S_DECIDE;
                end
                else if ({1'b0, uk_reg} + 1'b1 == used_cnt_reg)
                begin
                    res_st_next = ST_UNKNOWN;
                    state_next  = S_DONE;
                end
                else
                begin
                    uk_next    = uk_reg + 1'b1;
                    state_next = S_UREAD;
                end
            end
            S_DECIDE:
            begin
                mod_en_next = 1'b0;
                del_en_next = 1'b0;
                ins_en_next = 1'b0;
                t_next      = '0;
                state_next  = S_EDIT;
                if (kind_reg == KIND_ALLOC)
                begin
                    if (!found_reg)
                    begin
                        res_st_next = ST_NO_FIT;
                        state_next  = S_DONE;
                    end
                    else if (hit_reg.bytes >= size_reg + HDR32 + GRAIN32)
                    begin
                        mod_en_next        = 1'b1;
                        mod_idx_next       = hit_idx_reg;
                        mod_val_next.start = hit_reg.start + HDR32 + size_reg;
                        mod_val_next.bytes = hit_reg.bytes - size_reg - HDR32;
                        res_gr_next        = size_reg[15:0];
                        res_pay_next       = hit_reg.start + HDR32;
                    end
                    else
                    begin
                        del_en_next  = 1'b1;
                        del_idx_next = hit_idx_reg;
                        res_gr_next  = (hit_reg.bytes > 32'h0000_FFFF) ?
                                       16'hFFFF : hit_reg.bytes[15:0];
                        res_pay_next = hit_reg.start + HDR32;
                    end
                end
                else
                begin
                    priority if (nm && pm)
                    begin
                        mod_en_next        = 1'b1;
                        mod_idx_next       = prev_idx_reg;
                        mod_val_next.start = prev_reg.start;
                        mod_val_next.bytes = prev_reg.bytes + HDR32 + merged;
                        del_en_next        = 1'b1;
                        del_idx_next       = hit_idx_reg;
                    end
                    else if (nm)
                    begin
                        mod_en_next        = 1'b1;
                        mod_idx_next       = hit_idx_reg;
                        mod_val_next.start = h_reg;
                        mod_val_next.bytes = merged;
                    end
                    else if (pm)
                    begin
                        mod_en_next        = 1'b1;
                        mod_idx_next       = prev_idx_reg;
                        mod_val_next.start = prev_reg.start;
                        mod_val_next.bytes = prev_reg.bytes + HDR32 + size_reg;
                    end
                    else if (free_cnt_reg >= FREE_CNT_W'(FREE_SLOTS))
                    begin
                        res_st_next = ST_TABLE_FULL;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        ins_en_next        = 1'b1;
                        ins_idx_next       = found_reg ? hit_idx_reg :
                                             free_cnt_reg[FREE_IDX_W-1:0];
                        ins_val_next.start = h_reg;
                        ins_val_next.bytes = size_reg;
                    end
                end
            end
            S_EDIT:
            begin
                shift    = 1'b1;
                dly_next = head;
                tail     = base;
                if (ins_en_reg && (t_reg == ins_idx_reg))
                begin
                    tail = ins_val_reg;
                end
                if (mod_en_reg && (t_reg == mod_idx_reg))
                begin
                    tail = mod_val_reg;
                end
                t_next = t_reg + 1'b1;
                if (t_reg == LAST_T)
                begin
                    t_next = '0;
                    if (del_en_reg)
                    begin
                        free_cnt_next = free_cnt_reg - 1'b1;
                    end
                    else if (ins_en_reg)
                    begin
                        free_cnt_next = free_cnt_reg + 1'b1;
                    end
                    unique case (kind_reg)
                        KIND_ALLOC:
                        begin
                            we            = 1'b1;
                            wa            = used_cnt_reg[USED_IDX_W-1:0];
                            wd.start      = hit_reg.start;
                            wd.bytes      = res_gr_reg;
                            used_cnt_next = used_cnt_reg + 1'b1;
                            state_next    = S_DONE;
                        end
                        KIND_FREE:
                        begin
                            state_next = S_MVREAD;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_MVREAD:
            begin
                rd_addr    = USED_IDX_W'(used_cnt_reg - 1'b1);
                state_next = S_MVWAIT;
            end
            S_MVWAIT:
            begin
                we            = 1'b1;
                wa            = uk_reg;
                wd            = rd_data_reg;
                used_cnt_next = used_cnt_reg - 1'b1;
                state_next    = S_DONE;
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_pay_next   = (res_st_reg == ST_OK) ? res_pay_reg : '0;
                    rsp_gr_next    = (res_st_reg == ST_OK) ? res_gr_reg : '0;
                    rsp_st_next    = res_st_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            t_reg         <= '0;
            found_reg     <= 1'b0;
            dbl_reg       <= 1'b0;
            has_prev_reg  <= 1'b0;
            free_cnt_reg  <= '0;
            used_cnt_reg  <= '0;
            uk_reg        <= '0;
            mod_en_reg    <= 1'b0;
            del_en_reg    <= 1'b0;
            ins_en_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            t_reg         <= t_next;
            found_reg     <= found_next;
            dbl_reg       <= dbl_next;
            has_prev_reg  <= has_prev_next;
            free_cnt_reg  <= free_cnt_next;
            used_cnt_reg  <= used_cnt_next;
            uk_reg        <= uk_next;
            mod_en_reg    <= mod_en_next;
            del_en_reg    <= del_en_next;
            ins_en_reg    <= ins_en_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        req_reg      <= req_next;
        h_reg        <= h_next;
        size_reg     <= size_next;
        hit_idx_reg  <= hit_idx_next;
        prev_idx_reg <= prev_idx_next;
        hit_reg      <= hit_next;
        prev_reg     <= prev_next;
        mod_idx_reg  <= mod_idx_next;
        del_idx_reg  <= del_idx_next;
        ins_idx_reg  <= ins_idx_next;
        mod_val_reg  <= mod_val_next;
        ins_val_reg  <= ins_val_next;
        dly_reg      <= dly_next;
        res_pay_reg  <= res_pay_next;
        res_gr_reg   <= res_gr_next;
        res_st_reg   <= res_st_next;
        rsp_pay_reg  <= rsp_pay_next;
        rsp_gr_reg   <= rsp_gr_next;
        rsp_st_reg   <= rsp_st_next;
    end

    // granted-block table
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            used_mem[wa] <= wd;
        end
        rd_data_reg <= used_mem[rd_addr];
    end

endmodule

// ===== rtl/ffca_checker.sv =====
// ============================================================================
// ffca_checker
// Port-level checks of the allocator, bound to the top level.
// ============================================================================
module ffca_checker
    import ffca_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [31:0] rsp_payload_address,
    input logic [15:0] rsp_granted_bytes,
    input logic [2:0]  rsp_status
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response beat dropped while stalled");

    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=>
            $stable(rsp_payload_address) && $stable(rsp_granted_bytes) &&
            $stable(rsp_status))
        else $error("response beat changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("second request taken while one is in flight");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status != ST_OK) |->
            (rsp_payload_address == '0) && (rsp_granted_bytes == '0))
        else $error("failed response carries a grant");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_status <= ST_TABLE_FULL)
        else $error("undefined status code");

endmodule

bind first_fit_coalescing_allocator_unit ffca_checker u_ffca_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .req_valid           (req.valid),
    .req_ready           (req.ready),
    .rsp_valid           (rsp.valid),
    .rsp_ready           (rsp.ready),
    .rsp_payload_address (rsp.payload_address),
    .rsp_granted_bytes   (rsp.granted_bytes),
    .rsp_status          (rsp.status)
);

// ===== verif/ffca_tb_if.sv =====
`timescale 1ns / 100ps
// ============================================================================
// ffca testbench types
// Expected-answer record shared by the scoreboard; the channel interfaces
// come from the RTL interface file.
// ============================================================================
package ffca_tb_pkg;
    typedef struct {
        logic [31:0] payload_address;
        logic [15:0] granted_bytes;
        logic [2:0]  status;
    } alloc_answer_t;
endpackage

// ===== verif/first_fit_coalescing_allocator_unit_test.sv =====
`timescale 1ns / 100ps
// ============================================================================
// first_fit_coalescing_allocator_unit_test
// Drives allocate, free, add-page and no-op beats with random gaps on both
// channels; a behavioral heap model predicts every answer, checked in order.
// ============================================================================
module first_fit_coalescing_allocator_unit_test;
    import ffca_pkg::*;
    import ffca_tb_pkg::*;

    class heap_scoreboard;
        logic [31:0] fstart [$];
        logic [31:0] fbytes [$];
        logic [31:0] ustart [$];
        logic [15:0] ubytes [$];
        alloc_answer_t answers [$];
        int errors;

        function automatic logic [2:0] insert_block(logic [31:0] h, logic [31:0] size);
            int i;
            bit pm;
            bit nm;
            i = 0;
            foreach (fstart[k])
                if (fstart[k] == h)
                    return ST_DOUBLE;
            while (i < fstart.size() && fstart[i] < h)
                i++;
            nm = i < fstart.size() && h + HDR32 + size == fstart[i];
            pm = i > 0 && fstart[i-1] + HDR32 + fbytes[i-1] == h;
            if (nm)
            begin
                size = size + HDR32 + fbytes[i];
                if (pm)
                begin
                    fbytes[i-1] = fbytes[i-1] + HDR32 + size;
                    fstart.delete(i);
                    fbytes.delete(i);
                end
                else
                begin
                    fstart[i] = h;
                    fbytes[i] = size;
                end
                return ST_OK;
            end
            if (pm)
            begin
                fbytes[i-1] = fbytes[i-1] + HDR32 + size;
                return ST_OK;
            end
            if (fstart.size() >= FREE_SLOTS)
                return ST_TABLE_FULL;
            fstart.insert(i, h);
            fbytes.insert(i, size);
            return ST_OK;
        endfunction

        function automatic void note_request(logic [1:0] kind, logic [15:0] req,
                                             logic [31:0] addr);
            alloc_answer_t a;
            logic [31:0] size;
            logic [31:0] h;
            logic [31:0] rec;
            int i;
            int k;
            a = '{32'd0, 16'd0, ST_OK};
            if (kind == KIND_ALLOC)
            begin
                size = (32'(req) + ROUND32) & ~ROUND32;
                if (req == 0)
                    a.status = ST_ZERO_SIZE;
                else if (size + HDR32 > PAGE32)
                    a.status = ST_TOO_LARGE;
                else if (ustart.size() >= USED_SLOTS)
                    a.status = ST_TABLE_FULL;
                else
                begin
                    i = 0;
                    while (i < fstart.size() && fbytes[i] < size)
                        i++;
                    if (i >= fstart.size())
                        a.status = ST_NO_FIT;
                    else
                    begin
                        h = fstart[i];
                        if (fbytes[i] >= size + HDR32 + GRAIN32)
                        begin
                            fstart[i] = h + HDR32 + size;
                            fbytes[i] = fbytes[i] - size - HDR32;
                            rec = size;
                        end
                        else
                        begin
                            rec = fbytes[i];
                            fstart.delete(i);
                            fbytes.delete(i);
                        end
                        if (rec > 32'd65535)
                            rec = 32'd65535;
                        ustart.push_back(h);
                        ubytes.push_back(rec[15:0]);
                        a.payload_address = h + HDR32;
                        a.granted_bytes = rec[15:0];
                    end
                end
            end
            else if (kind == KIND_FREE)
            begin
                h = addr - HDR32;
                k = -1;
                foreach (fstart[j])
                    if (fstart[j] == h)
                        a.status = ST_DOUBLE;
                if (a.status == ST_OK)
                begin
                    foreach (ustart[j])
                        if (k < 0 && ustart[j] == h)
                            k = j;
                    if (k < 0)
                        a.status = ST_UNKNOWN;
                    else
                    begin
                        a.status = insert_block(h, 32'(ubytes[k]));
                        if (a.status == ST_OK)
                        begin
                            ustart[k] = ustart[ustart.size()-1];
                            ubytes[k] = ubytes[ubytes.size()-1];
                            void'(ustart.pop_back());
                            void'(ubytes.pop_back());
                        end
                    end
                end
            end
            else if (kind == KIND_ADD_PAGE)
                a.status = insert_block(addr, PAGE32 - HDR32);
            answers.push_back(a);
        endfunction

        function automatic void check_answer(logic [31:0] pa, logic [15:0] gb,
                                             logic [2:0] st);
            alloc_answer_t e;
            if (answers.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected answer pa=%h gb=%0d st=%0d", pa, gb, st);
                return;
            end
            e = answers.pop_front();
            if (e.payload_address !== pa || e.granted_bytes !== gb || e.status !== st)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: exp pa=%h gb=%0d st=%0d got pa=%h gb=%0d st=%0d",
                             e.payload_address, e.granted_bytes, e.status, pa, gb, st);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    ffca_req_if req ();
    ffca_rsp_if rsp ();
    heap_scoreboard board;
    int cycles = 0;
    logic [31:0] granted_pool [$];

    first_fit_coalescing_allocator_unit i_dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req.sink),
        .rsp  (rsp.source)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 150);
    endfunction

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 6000000)
        begin
            $display("first_fit_coalescing_allocator_unit_test failed");
            $finish;
        end
        if (rst_n && rsp.valid && rsp.ready)
            board.check_answer(rsp.payload_address, rsp.granted_bytes, rsp.status);
    end

    initial
    begin
        int g;
        forever
        begin
            @(negedge clk);
            g = gap_len();
            if (g == 0)
                rsp.ready <= 1'b1;
            else
            begin
                rsp.ready <= 1'b0;
                repeat (g) @(negedge clk);
                rsp.ready <= 1'b1;
            end
        end
    end

    task automatic send_beat(logic [1:0] kind, logic [15:0] rb, logic [31:0] addr);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            req.valid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        req.valid <= 1'b1;
        req.kind <= kind;
        req.request_bytes <= rb;
        req.address <= addr;
        do
            @(posedge clk);
        while (!req.ready);
        board.note_request(kind, rb, addr);
        if (kind == KIND_ALLOC && board.answers[board.answers.size()-1].status == ST_OK)
            granted_pool.push_back(board.answers[board.answers.size()-1].payload_address);
        @(negedge clk);
    endtask

    task automatic add_page(logic [31:0] base);
        send_beat(KIND_ADD_PAGE, 16'($urandom), base);
    endtask

    task automatic free_some();
        int i;
        logic [31:0] a;
        i = $urandom_range(0, granted_pool.size() - 1);
        a = granted_pool[i];
        granted_pool.delete(i);
        send_beat(KIND_FREE, 16'($urandom), a);
    endtask

    initial
    begin
        int r;
        int p;
        logic [31:0] pick;
        board = new();
        rst_n = 1'b0;
        req.valid = 1'b0;
        req.kind = KIND_NOP;
        req.request_bytes = '0;
        req.address = '0;
        rsp.ready = 1'b0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        send_beat(KIND_ALLOC, 16'd16, 32'd0);
        send_beat(KIND_FREE, 16'd0, 32'h0000_1020);
        send_beat(KIND_NOP, 16'hFFFF, 32'hFFFF_FFFF);
        add_page(32'h0001_0000);
        send_beat(KIND_ALLOC, 16'd0, 32'd0);
        send_beat(KIND_ALLOC, 16'hFFFF, 32'hFFFF_FFFF);
        send_beat(KIND_ALLOC, 16'd4065, 32'd0);
        send_beat(KIND_ALLOC, 16'd1, 32'd0);
        send_beat(KIND_ALLOC, 16'd100, 32'd0);
        add_page(32'h0001_0000);
        add_page(32'h0001_1000);
        add_page(32'hFFFF_F000);
        send_beat(KIND_ALLOC, 16'd4064, 32'd0);
        send_beat(KIND_ALLOC, 16'd4000, 32'd0);
        free_some();
        free_some();
        free_some();
        send_beat(KIND_FREE, 16'd0, 32'h0001_0020);
        send_beat(KIND_FREE, 16'd0, 32'h1234_5678);

        for (int n = 0; n < 1350; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 8 || board.fstart.size() == 0)
            begin
                p = $urandom_range(0, 40);
                if (board.fstart.size() >= 60 || $urandom_range(0, 9) == 0)
                    p = $urandom_range(0, 1048575);
                add_page(32'(p) << 12);
            end
            else if (r < 55)
                send_beat(KIND_ALLOC, (r < 50) ? 16'($urandom_range(1, 600))
                                               : 16'($urandom), 32'($urandom));
            else if (r < 92 && granted_pool.size() > 0)
                free_some();
            else if (r < 96 && granted_pool.size() > 0)
            begin
                pick = granted_pool[$urandom_range(0, granted_pool.size() - 1)];
                send_beat(KIND_FREE, 16'($urandom), pick ^ 32'h10);
            end
            else
                send_beat(2'($urandom_range(1, 3)), 16'($urandom), $urandom);
        end
        req.valid <= 1'b0;
        while (board.answers.size() > 0)
            @(posedge clk);
        repeat (700) @(posedge clk);
        if (board.errors == 0 && board.answers.size() == 0)
            $display("first_fit_coalescing_allocator_unit_test passed");
        else
            $display("first_fit_coalescing_allocator_unit_test failed");
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/ffca_pkg.sv
rtl/ffca_if.sv
rtl/ffca_cell.sv
rtl/ffca_free_chain.sv
rtl/first_fit_coalescing_allocator_unit.sv
rtl/ffca_checker.sv
verif/ffca_tb_if.sv
verif/first_fit_coalescing_allocator_unit_test.sv
